// File: design/tac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and constants for the transmit arm / cooldown interlock.
// ----------------------------------------------------------------------------
package tac_pkg;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 1;
	localparam int CMD_W     = 4;
	localparam int ACT_W     = 4;
	localparam int REJ_W     = 3;
	localparam int MS_W      = 8;

	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_W-1:0] ARM_WINDOW_RESET = 32'd60000;
	localparam logic [CFG_W-1:0] COOLDOWN_RESET   = 32'd10000;

	localparam logic [MS_W-1:0] SHORT_BURST_MS = 8'd100;
	localparam logic [MS_W-1:0] LONG_BURST_MS  = 8'd250;
	localparam logic [MS_W-1:0] NO_BURST_MS    = 8'd0;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ARM_WINDOW = 1'b0,
		CFG_COOLDOWN   = 1'b1
	} cfg_idx_t;

	typedef enum logic [0:0] {
		REQ_COMMAND  = 1'b0,
		REQ_COMPLETE = 1'b1
	} req_type_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_OFF        = 4'd0,
		CMD_HELP       = 4'd1,
		CMD_STATUS     = 4'd2,
		CMD_ARM        = 4'd3,
		CMD_CLEARFAULT = 4'd4,
		CMD_PA100      = 4'd5,
		CMD_PA250      = 4'd6,
		CMD_LEAK100    = 4'd7,
		CMD_LEAK250    = 4'd8,
		CMD_INVALID    = 4'd9
	} cmd_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_REJECTED = 4'd0,
		ACT_OFF      = 4'd1,
		ACT_HELP     = 4'd2,
		ACT_STATUS   = 4'd3,
		ACT_ARM      = 4'd4,
		ACT_CLEAR    = 4'd5,
		ACT_PA       = 4'd6,
		ACT_LEAK     = 4'd7,
		ACT_ACK      = 4'd8
	} action_t;

	typedef enum logic [REJ_W-1:0] {
		REJ_NONE        = 3'd0,
		REJ_INVALID     = 3'd1,
		REJ_NOT_ARMED   = 3'd2,
		REJ_EXPIRED     = 3'd3,
		REJ_COOLDOWN    = 3'd4,
		REJ_BUSY        = 3'd5,
		REJ_CLOCK_BACK  = 3'd6
	} rejection_t;

	// Class of an event as sorted by the front end
	typedef enum logic [2:0] {
		OP_ACK,
		OP_OFF,
		OP_HELP,
		OP_STATUS,
		OP_ARM,
		OP_CLEAR,
		OP_BURST,
		OP_INVALID
	} op_kind_t;

	typedef struct packed {
		op_kind_t        kind;
		action_t         act;   // burst action for OP_BURST
		logic [MS_W-1:0] ms;    // burst length for OP_BURST
	} op_t;

	localparam int OP_W = $bits(op_t);

endpackage

// File: design/tac_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_fifo
// Small register queue between the classify front end and the execute stage.
// ----------------------------------------------------------------------------
module tac_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             full,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_pop,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign full     = (cnt_q == FULL_CNT);
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && !full;
	assign pop      = rd_pop && rd_valid;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("queue count above depth");

	a_pop_leaves_room: assert property (@(posedge clk) disable iff (!arst_n)
		pop && !push |=> !full)
		else $error("queue still full after a pop");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> rd_valid)
		else $error("queue empty after a push");

endmodule

// File: design/tac_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_front
// Input register: accepts an event, sorts it into an operation class and
// hands it to the queue.
// ----------------------------------------------------------------------------
module tac_front #(
	parameter int TIME_BITS = 48
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    req_type,
	input  logic [tac_pkg::CMD_W-1:0] command,
	input  logic [TIME_BITS-1:0]    now_ms,
	output logic                    push_valid,
	input  logic                    push_full,
	output tac_pkg::op_t            op_s1,
	output logic [TIME_BITS-1:0]    time_s1
);

	import tac_pkg::*;

	logic valid_s1;
	logic accept;
	op_t  op_d;

	assign in_stall   = valid_s1 && push_full;
	assign accept     = in_valid && !in_stall;
	assign push_valid = valid_s1;

	always_comb begin
		op_d.kind = OP_INVALID;
		op_d.act  = ACT_REJECTED;
		op_d.ms   = NO_BURST_MS;
		if (req_type == REQ_COMPLETE) begin
			op_d.kind = OP_ACK;
		end else begin
			unique case (command)
				CMD_OFF:        op_d.kind = OP_OFF;
				CMD_HELP:       op_d.kind = OP_HELP;
				CMD_STATUS:     op_d.kind = OP_STATUS;
				CMD_ARM:        op_d.kind = OP_ARM;
				CMD_CLEARFAULT: op_d.kind = OP_CLEAR;
				CMD_PA100: begin
					op_d.kind = OP_BURST;
					op_d.act  = ACT_PA;
					op_d.ms   = SHORT_BURST_MS;
				end
				CMD_PA250: begin
					op_d.kind = OP_BURST;
					op_d.act  = ACT_PA;
					op_d.ms   = LONG_BURST_MS;
				end
				CMD_LEAK100: begin
					op_d.kind = OP_BURST;
					op_d.act  = ACT_LEAK;
					op_d.ms   = SHORT_BURST_MS;
				end
				CMD_LEAK250: begin
					op_d.kind = OP_BURST;
					op_d.act  = ACT_LEAK;
					op_d.ms   = LONG_BURST_MS;
				end
				default:        op_d.kind = OP_INVALID;  // invalid and unused codes
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!push_full) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= op_d;
			time_s1 <= now_ms;
		end
	end

endmodule

// File: design/tac_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_back
// Execute stage: holds the interlock state, applies one event per cycle while
// the result is not stalled and registers the result.
// ----------------------------------------------------------------------------
module tac_back #(
	parameter int TIME_BITS = 48
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [tac_pkg::CFG_W-1:0] arm_window_ms,
	input  logic [tac_pkg::CFG_W-1:0] cooldown_ms,
	input  logic                      q_valid,
	output logic                      q_pop,
	input  tac_pkg::op_t              q_op,
	input  logic [TIME_BITS-1:0]      q_time,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [tac_pkg::ACT_W-1:0] action,
	output logic [tac_pkg::REJ_W-1:0] rejection,
	output logic [tac_pkg::MS_W-1:0]  burst_ms,
	output logic                      armed_now,
	output logic [tac_pkg::CFG_W-1:0] cooldown_left_ms
);

	import tac_pkg::*;

	// interlock state
	logic                 armed_q, burst_q, cd_known_q, time_known_q;
	logic [TIME_BITS-1:0] arm_time_q, end_time_q, latest_q;

	logic                 armed_n, burst_n, cd_known_n, time_known_n;
	logic [TIME_BITS-1:0] arm_time_n, end_time_n, latest_n;

	logic                 out_valid_q;
	action_t              act_d;
	rejection_t           rej_d;
	logic [MS_W-1:0]      ms_d;
	logic                 an_d;
	logic [CFG_W-1:0]     cdl_d;

	logic                 late, valid_pre, expired, grant;
	logic [TIME_BITS-1:0] t, tc, tx, gone, since_arm, cd_ext, win_ext;
	logic [CFG_W-1:0]     cd_left;

	assign q_pop = q_valid && (!out_valid_q || !out_stall);
	assign t     = q_time;

	assign cd_ext  = TIME_BITS'(cooldown_ms);
	assign win_ext = TIME_BITS'(arm_window_ms);

	// a completion earlier than the watermark is clamped up to it
	assign late = time_known_q && (t < latest_q);
	assign tc   = late ? latest_q : t;
	assign tx   = (q_op.kind == OP_ACK) ? tc : t;

	assign gone = tx - end_time_q;
	always_comb begin
		if (!cd_known_q) begin
			cd_left = '0;
		end else if (tx < end_time_q) begin
			cd_left = cooldown_ms;
		end else if (gone >= cd_ext) begin
			cd_left = '0;
		end else begin
			cd_left = cooldown_ms - gone[CFG_W-1:0];
		end
	end

	assign since_arm = t - arm_time_q;
	assign valid_pre = armed_q && !burst_q && (t >= arm_time_q) &&
		(!time_known_q || (t >= latest_q)) && (since_arm < win_ext);
	assign expired   = armed_q && !valid_pre;

	always_comb begin
		armed_n      = armed_q;
		burst_n      = burst_q;
		cd_known_n   = cd_known_q;
		time_known_n = time_known_q;
		arm_time_n   = arm_time_q;
		end_time_n   = end_time_q;
		latest_n     = latest_q;
		act_d        = ACT_REJECTED;
		rej_d        = REJ_NONE;
		ms_d         = NO_BURST_MS;
		an_d         = 1'b0;
		cdl_d        = cd_left;
		grant        = 1'b0;

		priority if (q_op.kind == OP_ACK) begin
			armed_n      = 1'b0;
			latest_n     = tc;
			time_known_n = 1'b1;
			act_d        = ACT_ACK;
			if (burst_q) begin
				end_time_n = tc;
				cd_known_n = 1'b1;
				burst_n    = 1'b0;
				cdl_d      = cooldown_ms;  // cooldown starts right now
			end
		end else if (q_op.kind == OP_OFF) begin
			armed_n = 1'b0;
			act_d   = ACT_OFF;
			if (!late) begin
				latest_n     = t;
				time_known_n = 1'b1;
			end
		end else if (late) begin
			armed_n = 1'b0;
			rej_d   = REJ_CLOCK_BACK;
		end else begin
			latest_n     = t;
			time_known_n = 1'b1;
			armed_n      = valid_pre;
			priority if (q_op.kind == OP_HELP) begin
				act_d = ACT_HELP;
				an_d  = valid_pre;
			end else if (q_op.kind == OP_STATUS) begin
				act_d = ACT_STATUS;
				an_d  = valid_pre;
			end else if (q_op.kind == OP_INVALID) begin
				armed_n = 1'b0;
				rej_d   = REJ_INVALID;
			end else if (burst_q) begin
				armed_n = 1'b0;
				rej_d   = REJ_BUSY;
			end else if (q_op.kind == OP_CLEAR) begin
				armed_n = 1'b0;
				act_d   = ACT_CLEAR;
			end else if (cd_left != '0) begin
				armed_n = 1'b0;
				rej_d   = REJ_COOLDOWN;
			end else if (q_op.kind == OP_ARM) begin
				armed_n    = 1'b1;
				arm_time_n = t;
				act_d      = ACT_ARM;
				an_d       = (arm_window_ms != '0);
			end else if (!valid_pre) begin
				armed_n = 1'b0;
				rej_d   = expired ? REJ_EXPIRED : REJ_NOT_ARMED;
			end else begin
				armed_n = 1'b0;
				burst_n = 1'b1;
				act_d   = q_op.act;
				ms_d    = q_op.ms;
				grant   = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q      <= 1'b0;
			burst_q      <= 1'b0;
			cd_known_q   <= 1'b0;
			time_known_q <= 1'b0;
			arm_time_q   <= '0;
			end_time_q   <= '0;
			latest_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (q_pop) begin
				armed_q      <= armed_n;
				burst_q      <= burst_n;
				cd_known_q   <= cd_known_n;
				time_known_q <= time_known_n;
				arm_time_q   <= arm_time_n;
				end_time_q   <= end_time_n;
				latest_q     <= latest_n;
				out_valid_q  <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			action           <= act_d;
			rejection        <= rej_d;
			burst_ms         <= ms_d;
			armed_now        <= an_d;
			cooldown_left_ms <= cdl_d;
		end
	end

	assign out_valid = out_valid_q;

	a_grant_sets_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && grant |=> burst_q && !armed_q)
		else $error("granted burst did not mark busy");

	a_reject_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && (act_d == ACT_REJECTED) |=> !armed_q)
		else $error("rejection left interlock armed");

	a_armed_now_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && an_d |=> armed_q && !burst_q)
		else $error("armed_now reported without arm state");

	a_watermark_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop && time_known_q |=> latest_q >= $past(latest_q))
		else $error("time watermark moved backwards");

endmodule

// File: design/transmit_arm_cooldown_interlock.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// transmit_arm_cooldown_interlock
// Arm / cooldown safety interlock for amplifier bursts.
//
//   channel  | handshake          | payload
//   ---------+--------------------+------------------------------------------
//   input    | in_valid/in_stall  | req_type, command, now_ms
//   result   | out_valid/out_stall| action, rejection, burst_ms, armed_now,
//            |                    | cooldown_left_ms
//   config   | cfg_we             | cfg_idx, cfg_data
//
// One event per cycle sustained while the result is not stalled; each event
// passes the input register, the queue and the execute/result register. The
// execute stage sets the rate: it reads and updates the interlock state once
// per event. Reset clears all state, empties the queue and loads the default
// window and cooldown. A stalled result backs up the queue; in_stall rises
// only when the input register holds an event and the queue is full.
// ----------------------------------------------------------------------------
module transmit_arm_cooldown_interlock #(
	parameter int TIME_BITS = 48
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [tac_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [tac_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          req_type,
	input  logic [tac_pkg::CMD_W-1:0]     command,
	input  logic [TIME_BITS-1:0]          now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tac_pkg::ACT_W-1:0]     action,
	output logic [tac_pkg::REJ_W-1:0]     rejection,
	output logic [tac_pkg::MS_W-1:0]      burst_ms,
	output logic                          armed_now,
	output logic [tac_pkg::CFG_W-1:0]     cooldown_left_ms
);

	import tac_pkg::*;

	localparam int ENTRY_W = OP_W + TIME_BITS;

	logic [CFG_W-1:0]     arm_window_q, cooldown_q;
	logic                 push_valid, q_full, q_valid, q_pop;
	op_t                  op_s1, q_op;
	logic [TIME_BITS-1:0] time_s1, q_time;
	logic [ENTRY_W-1:0]   q_rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arm_window_q <= ARM_WINDOW_RESET;
			cooldown_q   <= COOLDOWN_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_ARM_WINDOW: arm_window_q <= cfg_data;
				CFG_COOLDOWN:   cooldown_q   <= cfg_data;
				default:        ;
			endcase
		end
	end

	tac_front #(
		.TIME_BITS (TIME_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.command    (command),
		.now_ms     (now_ms),
		.push_valid (push_valid),
		.push_full  (q_full),
		.op_s1      (op_s1),
		.time_s1    (time_s1)
	);

	tac_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (push_valid),
		.full     (q_full),
		.wr_data  ({op_s1, time_s1}),
		.rd_valid (q_valid),
		.rd_pop   (q_pop),
		.rd_data  (q_rd_data)
	);

	assign q_op   = op_t'(q_rd_data[ENTRY_W-1:TIME_BITS]);
	assign q_time = q_rd_data[TIME_BITS-1:0];

	tac_back #(
		.TIME_BITS (TIME_BITS)
	) u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.arm_window_ms    (arm_window_q),
		.cooldown_ms      (cooldown_q),
		.q_valid          (q_valid),
		.q_pop            (q_pop),
		.q_op             (q_op),
		.q_time           (q_time),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.action           (action),
		.rejection        (rejection),
		.burst_ms         (burst_ms),
		.armed_now        (armed_now),
		.cooldown_left_ms (cooldown_left_ms)
	);

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the transmit arm / cooldown interlock. An in-bench
// interlock model predicts every result as each transaction is accepted; a
// checker compares results field by field in order. Directed sequences cover
// arm/grant/complete/cooldown paths, the clock-backwards rules and extreme
// window and cooldown settings; random phases run arm/burst/complete cycles
// mixed with noise, under random idling, a quiet stretch and a long
// receiver hold-off.
// ----------------------------------------------------------------------------
module testbench;
	import tac_pkg::*;

	localparam int TB = 48;
	localparam int IDLE_PCT = 16;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd10;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
	localparam logic [TB-1:0] TIME_MAX = '1;

	typedef struct packed {
		action_t         act;
		rejection_t      rej;
		logic [MS_W-1:0] ms;
		logic            armed;
		logic [CFG_W-1:0] cool_left;
	} verdict_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic                 req_type = 1'b0;
	logic [CMD_W-1:0]     command = '0;
	logic [TB-1:0]        now_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [ACT_W-1:0]     action;
	logic [REJ_W-1:0]     rejection;
	logic [MS_W-1:0]      burst_ms;
	logic                 armed_now;
	logic [CFG_W-1:0]     cooldown_left_ms;

	transmit_arm_cooldown_interlock #(.TIME_BITS(TB)) dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .command(command), .now_ms(now_ms),
		.out_valid(out_valid), .out_stall(out_stall),
		.action(action), .rejection(rejection), .burst_ms(burst_ms),
		.armed_now(armed_now), .cooldown_left_ms(cooldown_left_ms)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// interlock model state
	logic [CFG_W-1:0] win_ms;
	logic [CFG_W-1:0] cool_ms;
	logic             il_armed;
	logic [TB-1:0]    il_arm_t;
	logic             il_busy;
	logic [TB-1:0]    il_end_t;
	logic             il_cool_known;
	logic [TB-1:0]    il_mark;
	logic             il_mark_known;

	verdict_t expected_results[$];
	logic [TB-1:0] wall = '0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;
	int hold_left = 0;
	int errors = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_grants = 0;
	int n_rejects = 0;

	function automatic void reset_model();
		win_ms = ARM_WINDOW_RESET;
		cool_ms = COOLDOWN_RESET;
		il_armed = 1'b0;
		il_arm_t = '0;
		il_busy = 1'b0;
		il_end_t = '0;
		il_cool_known = 1'b0;
		il_mark = '0;
		il_mark_known = 1'b0;
	endfunction

	function automatic logic arm_ok(input logic [TB-1:0] t);
		return il_armed && !il_busy && t >= il_arm_t && (!il_mark_known || t >= il_mark) &&
			((t - il_arm_t) < {16'b0, win_ms});
	endfunction

	function automatic logic [CFG_W-1:0] cool_remaining(input logic [TB-1:0] t);
		logic [TB-1:0] gone;
		if (!il_cool_known)
			return '0;
		if (t < il_end_t)
			return cool_ms;
		gone = t - il_end_t;
		if (gone >= {16'b0, cool_ms})
			return '0;
		return cool_ms - gone[CFG_W-1:0];
	endfunction

	function automatic verdict_t make_verdict(input action_t a, input rejection_t r,
			input logic [MS_W-1:0] ms, input logic [TB-1:0] t);
		verdict_t v;
		v.act = a;
		v.rej = r;
		v.ms = ms;
		v.armed = arm_ok(t);
		v.cool_left = cool_remaining(t);
		return v;
	endfunction

	function automatic verdict_t refuse(input rejection_t r, input logic [TB-1:0] t);
		il_armed = 1'b0;
		return make_verdict(ACT_REJECTED, r, NO_BURST_MS, t);
	endfunction

	function automatic verdict_t judge_event(input logic rt, input logic [CMD_W-1:0] cmd,
			input logic [TB-1:0] t_in);
		logic [TB-1:0]   t;
		logic            lapsed;
		action_t         act;
		logic [MS_W-1:0] ms;
		t = t_in;
		ms = NO_BURST_MS;
		act = ACT_REJECTED;
		if (rt == REQ_COMPLETE) begin
			il_armed = 1'b0;
			if (il_mark_known && t < il_mark)
				t = il_mark;
			il_mark = t;
			il_mark_known = 1'b1;
			if (il_busy) begin
				il_end_t = t;
				il_cool_known = 1'b1;
				il_busy = 1'b0;
			end
			return make_verdict(ACT_ACK, REJ_NONE, NO_BURST_MS, t);
		end
		if (cmd == CMD_OFF) begin
			il_armed = 1'b0;
			if (!il_mark_known || t >= il_mark) begin
				il_mark = t;
				il_mark_known = 1'b1;
			end
			return make_verdict(ACT_OFF, REJ_NONE, NO_BURST_MS, t);
		end
		if (il_mark_known && t < il_mark)
			return refuse(REJ_CLOCK_BACK, t);
		il_mark = t;
		il_mark_known = 1'b1;
		lapsed = il_armed && !arm_ok(t);
		if (lapsed)
			il_armed = 1'b0;
		case (cmd)
			CMD_HELP: return make_verdict(ACT_HELP, REJ_NONE, NO_BURST_MS, t);
			CMD_STATUS: return make_verdict(ACT_STATUS, REJ_NONE, NO_BURST_MS, t);
			CMD_ARM: act = ACT_ARM;
			CMD_CLEARFAULT: act = ACT_CLEAR;
			CMD_PA100: begin
				act = ACT_PA;
				ms = SHORT_BURST_MS;
			end
			CMD_PA250: begin
				act = ACT_PA;
				ms = LONG_BURST_MS;
			end
			CMD_LEAK100: begin
				act = ACT_LEAK;
				ms = SHORT_BURST_MS;
			end
			CMD_LEAK250: begin
				act = ACT_LEAK;
				ms = LONG_BURST_MS;
			end
			default: return refuse(REJ_INVALID, t);
		endcase
		if (il_busy)
			return refuse(REJ_BUSY, t);
		if (act == ACT_CLEAR) begin
			il_armed = 1'b0;
			return make_verdict(ACT_CLEAR, REJ_NONE, NO_BURST_MS, t);
		end
		if (cool_remaining(t) != '0)
			return refuse(REJ_COOLDOWN, t);
		if (act == ACT_ARM) begin
			il_armed = 1'b1;
			il_arm_t = t;
			return make_verdict(ACT_ARM, REJ_NONE, NO_BURST_MS, t);
		end
		if (!il_armed)
			return refuse(lapsed ? REJ_EXPIRED : REJ_NOT_ARMED, t);
		il_armed = 1'b0;
		il_busy = 1'b1;
		return make_verdict(act, REJ_NONE, ms, t);
	endfunction

	// receiver: random stalls, or a counted hold-off when requested
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else begin
			out_stall <= rx_idle_on && ($urandom_range(99, 0) < IDLE_PCT);
		end
	end

	task automatic report_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin : check_results
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: result with nothing expected: expected none, actual action %0d",
					$time, action);
				errors++;
			end else begin
				want = expected_results.pop_front();
				report_field("action", 32'(want.act), 32'(action));
				report_field("rejection", 32'(want.rej), 32'(rejection));
				report_field("burst_ms", 32'(want.ms), 32'(burst_ms));
				report_field("armed_now", 32'(want.armed), 32'(armed_now));
				report_field("cooldown_left_ms", want.cool_left, cooldown_left_ms);
				n_checked++;
				if (action == ACT_PA || action == ACT_LEAK)
					n_grants++;
				if (action == ACT_REJECTED)
					n_rejects++;
			end
		end
	end

	task automatic send_event(input logic rt, input logic [CMD_W-1:0] cmd,
			input logic [TB-1:0] t);
		while (tx_idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rt;
		command <= cmd;
		now_ms <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_results.push_back(judge_event(rt, cmd, t));
		n_sent++;
	endtask

	// let every pending transaction drain before touching registers
	task automatic settle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ARM_WINDOW)
			win_ms = data;
		else
			cool_ms = data;
		@(posedge clk);
	endtask

	function automatic logic [TB-1:0] rand_upto(input logic [63:0] hi);
		logic [63:0] r;
		if (hi <= 64'hFFFF_FFFF)
			return TB'($urandom_range(hi[31:0], 0));
		r = {$urandom, $urandom};
		return TB'(r % (hi + 64'd1));
	endfunction

	function automatic logic [CMD_W-1:0] pick_burst();
		case ($urandom_range(3, 0))
			0: return CMD_PA100;
			1: return CMD_PA250;
			2: return CMD_LEAK100;
			default: return CMD_LEAK250;
		endcase
	endfunction

	task automatic set_random_config();
		logic [CFG_W-1:0] w;
		logic [CFG_W-1:0] c;
		case ($urandom_range(9, 0))
			0: w = $urandom;
			1: w = $urandom_range(3, 1);
			default: w = $urandom_range(3000, 1);
		endcase
		case ($urandom_range(9, 0))
			0: c = $urandom;
			1, 2: c = '0;
			default: c = $urandom_range(2000, 0);
		endcase
		write_reg(CFG_ARM_WINDOW, w);
		write_reg(CFG_COOLDOWN, c);
	endtask

	// arm / burst / complete / cooldown cycle with random timing
	task automatic burst_cycle();
		logic [CMD_W-1:0] pick;
		logic [TB-1:0]    dur;
		send_event(REQ_COMMAND, CMD_ARM, wall);
		if ($urandom_range(99, 0) < 20) begin
			wall = wall + $urandom_range(5, 0);
			send_event(REQ_COMMAND, $urandom_range(1, 0) ? CMD_STATUS : CMD_HELP, wall);
		end
		wall = wall + rand_upto(64'(win_ms) + 64'(win_ms / 8));
		pick = pick_burst();
		send_event(REQ_COMMAND, pick, wall);
		if ($urandom_range(99, 0) < 15)
			send_event(REQ_COMMAND, pick_burst(), wall + $urandom_range(50, 0));
		dur = TB'((pick == CMD_PA100 || pick == CMD_LEAK100) ? SHORT_BURST_MS
			: LONG_BURST_MS);
		wall = wall + dur + $urandom_range(20, 0);
		if ($urandom_range(99, 0) < 10 && wall > 1000)
			send_event(REQ_COMPLETE, CMD_W'($urandom_range(CMD_UNUSED_HI, 0)), wall - 400);
		else
			send_event(REQ_COMPLETE, CMD_W'($urandom_range(CMD_UNUSED_HI, 0)), wall);
		wall = wall + rand_upto(64'(cool_ms) + 64'(cool_ms / 8) + 64'd1);
	endtask

	task automatic send_noise();
		logic [TB-1:0] t;
		logic          rt;
		rt = ($urandom_range(99, 0) < 25);
		if ($urandom_range(99, 0) < 20 && wall > 1000) begin
			t = wall - $urandom_range(999, 1);
		end else begin
			wall = wall + $urandom_range(300, 0);
			t = wall;
		end
		send_event(rt, CMD_W'($urandom_range(CMD_UNUSED_HI, 0)), t);
	endtask

	// each phase lives in its own slice of the 48-bit time range
	task automatic run_traffic(input logic [2:0] slice, input int count, input bit squeeze);
		logic [63:0] r;
		int          stop;
		settle();
		set_random_config();
		r = {$urandom, $urandom};
		wall = {slice, 1'b0, r[43:0]};
		if (squeeze)
			hold_left = 150;
		stop = n_sent + count;
		while (n_sent < stop) begin
			if ($urandom_range(99, 0) < 70)
				burst_cycle();
			else
				send_noise();
		end
	endtask

	task automatic test_reset_defaults();
		send_event(REQ_COMMAND, CMD_STATUS, 48'd0);
		send_event(REQ_COMMAND, CMD_PA100, 48'd10);
		send_event(REQ_COMMAND, CMD_ARM, 48'd1000);
		send_event(REQ_COMMAND, CMD_PA100, 48'd1050);
		send_event(REQ_COMMAND, CMD_LEAK250, 48'd1060);
		send_event(REQ_COMPLETE, CMD_OFF, 48'd1150);
		// backward status right after completion: time before burst end
		send_event(REQ_COMMAND, CMD_STATUS, 48'd1100);
		send_event(REQ_COMMAND, CMD_ARM, 48'd2000);
		// stale completion with no burst running, junk in the command field
		send_event(REQ_COMPLETE, CMD_UNUSED_HI, 48'd1500);
		send_event(REQ_COMMAND, CMD_ARM, 48'd11150);
		send_event(REQ_COMMAND, CMD_HELP, 48'd11160);
		send_event(REQ_COMMAND, CMD_LEAK250, 48'd11200);
		send_event(REQ_COMPLETE, CMD_LEAK250, 48'd11000);
		send_event(REQ_COMMAND, CMD_ARM, 48'd21200);
		send_event(REQ_COMMAND, CMD_PA250, 48'd81200);
		send_event(REQ_COMMAND, CMD_CLEARFAULT, 48'd81300);
		send_event(REQ_COMMAND, CMD_INVALID, 48'd81400);
		send_event(REQ_COMMAND, CMD_UNUSED_LO, 48'd81500);
		send_event(REQ_COMMAND, CMD_OFF, 48'd81000);
		send_event(REQ_COMMAND, CMD_STATUS, 48'd80000);
		send_event(REQ_COMMAND, CMD_ARM, 48'd90000);
		send_event(REQ_COMMAND, CMD_OFF, 48'd90000);
		wall = 48'd100000;
	endtask

	task automatic test_window_extremes();
		settle();
		write_reg(CFG_ARM_WINDOW, '0);
		write_reg(CFG_COOLDOWN, '0);
		// zero window: arm never counts
		send_event(REQ_COMMAND, CMD_ARM, wall);
		send_event(REQ_COMMAND, CMD_PA100, wall);
		settle();
		write_reg(CFG_ARM_WINDOW, 32'd1);
		wall = wall + 10;
		send_event(REQ_COMMAND, CMD_ARM, wall);
		send_event(REQ_COMMAND, CMD_STATUS, wall);
		send_event(REQ_COMMAND, CMD_PA250, wall + 1);
		settle();
		write_reg(CFG_ARM_WINDOW, '1);
		wall = wall + 10;
		send_event(REQ_COMMAND, CMD_ARM, wall);
		send_event(REQ_COMMAND, CMD_LEAK100, wall);
		wall = wall + 100;
		send_event(REQ_COMPLETE, CMD_OFF, wall);
		send_event(REQ_COMMAND, CMD_ARM, wall);
		wall = wall + 48'hFFFF_FFF0;
		send_event(REQ_COMMAND, CMD_PA250, wall);
		wall = wall + 300;
		send_event(REQ_COMPLETE, CMD_OFF, wall);
	endtask

	task automatic test_random_traffic();
		run_traffic(3'd1, 200, 1'b0);
		run_traffic(3'd2, 200, 1'b0);
		run_traffic(3'd3, 200, 1'b0);
		run_traffic(3'd4, 200, 1'b0);
	endtask

	task automatic test_quiet_stretch();
		tx_idle_on = 1'b0;
		rx_idle_on = 1'b0;
		run_traffic(3'd5, 200, 1'b0);
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
	endtask

	task automatic test_backpressure();
		run_traffic(3'd6, 200, 1'b1);
	endtask

	// time at the top of the 48-bit range, window and cooldown at maximum
	task automatic test_time_limits();
		settle();
		write_reg(CFG_ARM_WINDOW, '1);
		write_reg(CFG_COOLDOWN, '1);
		wall = TIME_MAX - 48'd255;
		send_event(REQ_COMMAND, CMD_ARM, wall);
		send_event(REQ_COMMAND, CMD_PA250, wall + 10);
		send_event(REQ_COMPLETE, CMD_OFF, TIME_MAX);
		send_event(REQ_COMMAND, CMD_STATUS, TIME_MAX);
		send_event(REQ_COMMAND, CMD_ARM, TIME_MAX);
		send_event(REQ_COMMAND, CMD_OFF, '0);
		send_event(REQ_COMPLETE, CMD_PA100, '0);
		send_event(REQ_COMMAND, CMD_LEAK100, TIME_MAX);
	endtask

	initial begin
		int guard;
		reset_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_window_extremes();
		test_random_traffic();
		test_quiet_stretch();
		test_backpressure();
		test_time_limits();

		in_valid <= 1'b0;
		guard = 0;
		while (expected_results.size() != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		if (expected_results.size() != 0) begin
			$display("%0t: results missing: expected %0d more, actual 0",
				$time, expected_results.size());
			errors += expected_results.size();
		end
		repeat (10) @(posedge clk);

		$display("Ran %0d events, checked %0d results: %0d bursts granted, %0d rejected.",
			n_sent, n_checked, n_grants, n_rejects);
		$display("Covered zero/one/max arm window, zero/max cooldown, times up to 2^48-1.");
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Timeout at %0t", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
